// ===== src/assert_macros.svh =====
// Assertion macros used by the top level of the RTF escaper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== src/u2r_pkg.sv =====
// Shared types and character constants of the UTF-8 to RTF escaper.
`timescale 1ns / 1ps

package u2r_pkg;

    // One output segment: a plain ASCII character or a \u escape value
    typedef struct packed {
        logic        esc;
        logic [15:0] val;
    } seg_t;

    // One classified input byte: one or two segments
    typedef struct packed {
        seg_t s0;
        seg_t s1;
        logic two;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Code point limits and surrogate bases
    localparam logic [20:0] ASCII_MAX    = 21'h00007F;
    localparam logic [20:0] BMP_MAX      = 21'h00FFFF;
    localparam logic [20:0] SUPP_BASE    = 21'h010000;
    localparam logic [15:0] SURR_HI_BASE = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE = 16'hDC00;

    // ASCII characters used in the RTF text
    localparam logic [6:0] CH_LF     = 7'h0A;
    localparam logic [6:0] CH_CR     = 7'h0D;
    localparam logic [6:0] CH_SPACE  = 7'h20;
    localparam logic [6:0] CH_MINUS  = 7'h2D;
    localparam logic [6:0] CH_ZERO   = 7'h30;
    localparam logic [6:0] CH_QMARK  = 7'h3F;
    localparam logic [6:0] CH_BSL    = 7'h5C;
    localparam logic [6:0] CH_E      = 7'h65;
    localparam logic [6:0] CH_I      = 7'h69;
    localparam logic [6:0] CH_L      = 7'h6C;
    localparam logic [6:0] CH_N      = 7'h6E;
    localparam logic [6:0] CH_U      = 7'h75;
    localparam logic [6:0] CH_LBRACE = 7'h7B;
    localparam logic [6:0] CH_RBRACE = 7'h7D;

endpackage

// ===== src/u2r_fifo.sv =====
// Small register FIFO used between the escaper stages and at the result side.
`timescale 1ns / 1ps

module u2r_fifo
    import u2r_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy on each transfer
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== src/u2r_front.sv =====
// Front stage: UTF-8 sequence tracking and classification into output segments.
`timescale 1ns / 1ps

module u2r_front
    import u2r_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] in_byte,
    input  logic       end_of_string,
    input  logic       q_full,
    output logic       q_push,
    output entry_t     q_entry
);

    logic [1:0]  need_reg, need_next;
    logic [1:0]  have_reg, have_next;
    logic [7:0]  lead_reg, cont1_reg, cont2_reg;
    logic        lead_we, cont1_we, cont2_we;
    logic        acc;
    logic [1:0]  extra;
    logic [7:0]  b1, b2;
    logic [20:0] cp_asm;
    logic [20:0] cp_a;
    logic [20:0] cp_off;
    logic        a_ok, b_ok, a_live, b_live;
    logic [6:0]  b_ch;

    function automatic logic [1:0] lead_extra(input logic [7:0] c);
        logic [1:0] k;
        k = 2'd0;
        if (c[7:5] == 3'b110)
        begin
            k = 2'd1;
        end
        else if (c[7:4] == 4'b1110)
        begin
            k = 2'd2;
        end
        else if (c[7:3] == 5'b11110)
        begin
            k = 2'd3;
        end
        return k;
    endfunction

    assign acc   = push && !q_full;
    assign extra = lead_extra(in_byte);

    // Continuation bytes as they stand once the incoming byte is placed
    assign b1 = (have_reg == 2'd0) ? in_byte : cont1_reg;
    assign b2 = (have_reg == 2'd1) ? in_byte : cont2_reg;

    // Assemble a complete sequence, low six bits of each continuation
    always_comb
    begin
        case (need_reg)
            2'd1:    cp_asm = {10'd0, lead_reg[4:0], b1[5:0]};
            2'd2:    cp_asm = {5'd0, lead_reg[3:0], b1[5:0], b2[5:0]};
            2'd3:    cp_asm = {lead_reg[2:0], b1[5:0], b2[5:0], in_byte[5:0]};
            default: cp_asm = '0;
        endcase
    end

    // Track the pending sequence and pick up to two code points
    always_comb
    begin
        need_next = need_reg;
        have_next = have_reg;
        lead_we   = 1'b0;
        cont1_we  = 1'b0;
        cont2_we  = 1'b0;
        cp_a      = '0;
        a_ok      = 1'b0;
        b_ch      = '0;
        b_ok      = 1'b0;
        if (need_reg == 2'd0)
        begin
            if (!in_byte[7])
            begin
                cp_a = {13'd0, in_byte};
                a_ok = 1'b1;
            end
            else if (extra != 2'd0 && !end_of_string)
            begin
                lead_we   = 1'b1;
                need_next = extra;
                have_next = 2'd0;
            end
        end
        else
        begin
            cont1_we = (have_reg == 2'd0);
            cont2_we = (have_reg == 2'd1);
            if (({1'b0, have_reg} + 3'd1) >= {1'b0, need_reg})
            begin
                cp_a      = cp_asm;
                a_ok      = 1'b1;
                need_next = 2'd0;
                have_next = 2'd0;
            end
            else if (end_of_string)
            begin
                // Drop the lead and decode the buffered bytes afresh
                if (have_reg == 2'd0)
                begin
                    if (!in_byte[7])
                    begin
                        cp_a = {13'd0, in_byte};
                        a_ok = 1'b1;
                    end
                end
                else if (!cont1_reg[7])
                begin
                    cp_a = {13'd0, cont1_reg};
                    a_ok = 1'b1;
                    if (!in_byte[7])
                    begin
                        b_ch = in_byte[6:0];
                        b_ok = 1'b1;
                    end
                end
                else if (cont1_reg[7:5] == 3'b110)
                begin
                    cp_a = {10'd0, cont1_reg[4:0], in_byte[5:0]};
                    a_ok = 1'b1;
                end
                else if (!in_byte[7])
                begin
                    cp_a = {13'd0, in_byte};
                    a_ok = 1'b1;
                end
            end
            else
            begin
                have_next = have_reg + 2'd1;
            end
        end
        if (end_of_string)
        begin
            need_next = 2'd0;
            have_next = 2'd0;
        end
    end

    // Code point zero and carriage return give no text
    assign a_live = a_ok && (cp_a != '0) && (cp_a != 21'(CH_CR));
    assign b_live = b_ok && (b_ch != '0) && (b_ch != CH_CR);
    assign cp_off = cp_a - SUPP_BASE;

    // Split into segments; above the BMP into a surrogate pair
    always_comb
    begin
        q_entry = '0;
        if (a_live)
        begin
            if (cp_a <= ASCII_MAX)
            begin
                q_entry.s0 = '{esc: 1'b0, val: {9'd0, cp_a[6:0]}};
            end
            else if (cp_a <= BMP_MAX)
            begin
                q_entry.s0 = '{esc: 1'b1, val: cp_a[15:0]};
            end
            else
            begin
                q_entry.s0 = '{esc: 1'b1, val: SURR_HI_BASE + {5'd0, cp_off[20:10]}};
                q_entry.s1 = '{esc: 1'b1, val: SURR_LO_BASE | {6'd0, cp_a[9:0]}};
                q_entry.two = 1'b1;
            end
            if (b_live)
            begin
                q_entry.s1  = '{esc: 1'b0, val: {9'd0, b_ch}};
                q_entry.two = 1'b1;
            end
        end
        else if (b_live)
        begin
            q_entry.s0 = '{esc: 1'b0, val: {9'd0, b_ch}};
        end
    end

    assign q_push = acc && (a_live || b_live);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_reg <= 2'd0;
            have_reg <= 2'd0;
        end
        else if (acc)
        begin
            need_reg <= need_next;
            have_reg <= have_next;
        end
    end

    // Hold the lead and continuation bytes of the pending sequence
    always_ff @(posedge clk)
    begin
        if (acc && lead_we)
        begin
            lead_reg <= in_byte;
        end
        if (acc && cont1_we)
        begin
            cont1_reg <= in_byte;
        end
        if (acc && cont2_we)
        begin
            cont2_reg <= in_byte;
        end
    end

endmodule

// ===== src/u2r_back.sv =====
// Back stage: expands segments into RTF characters, one per cycle while the result queue has room.
`timescale 1ns / 1ps

module u2r_back
    import u2r_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  entry_t     q_entry,
    input  logic       q_empty,
    output logic       q_pop,
    input  logic       o_full,
    output logic       o_push,
    output logic [6:0] o_char,
    output logic       o_last
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_PFX,
        PH_CHAR,
        PH_LINE,
        PH_UBSL,
        PH_U,
        PH_MINUS,
        PH_DIGIT,
        PH_QMARK
    } phase_t;

    typedef struct packed {
        logic [3:0]  digit;
        logic [15:0] rem;
    } dig_t;

    phase_t      phase_reg, phase_next;
    logic [6:0]  char_reg, char_next;
    logic [2:0]  line_reg, line_next;
    logic        neg_reg, neg_next;
    logic [15:0] mag_reg, mag_next;
    logic [2:0]  pidx_reg, pidx_next;
    seg_t        seg1_reg, seg1_next;
    logic        two_reg, two_next;
    logic [3:0]  cnt_reg, cnt_next;

    seg_t        src;
    phase_t      st_phase;
    logic [6:0]  st_char;
    logic        st_neg;
    logic [15:0] st_mag;
    logic [2:0]  st_pidx;
    logic        emit, seg_done, item_done, cap, load, from_seg1;
    dig_t        dig;

    function automatic logic [16:0] pow10(input logic [2:0] idx);
        logic [16:0] p;
        case (idx)
            3'd0:    p = 17'd1;
            3'd1:    p = 17'd10;
            3'd2:    p = 17'd100;
            3'd3:    p = 17'd1000;
            default: p = 17'd10000;
        endcase
        return p;
    endfunction

    // One decimal digit, most significant first, by a ladder of compares
    function automatic dig_t digit_step(input logic [15:0] rem, input logic [2:0] idx);
        dig_t        r;
        logic [16:0] p;
        logic [16:0] sub;
        p       = pow10(idx);
        sub     = '0;
        r.digit = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if ({1'b0, rem} >= 17'(17'(k) * p))
            begin
                r.digit = 4'(k);
                sub     = 17'(17'(k) * p);
            end
        end
        r.rem = 16'({1'b0, rem} - sub);
        return r;
    endfunction

    function automatic logic [6:0] line_char(input logic [2:0] idx);
        logic [6:0] c;
        case (idx)
            3'd0:    c = CH_BSL;
            3'd1:    c = CH_L;
            3'd2:    c = CH_I;
            3'd3:    c = CH_N;
            3'd4:    c = CH_E;
            default: c = CH_SPACE;
        endcase
        return c;
    endfunction

    assign dig       = digit_step(mag_reg, pidx_reg);
    assign emit      = (phase_reg != PH_IDLE) && !o_full;
    assign cap       = (cnt_reg == 4'd15);
    assign item_done = (seg_done && !two_reg) || cap;
    assign from_seg1 = emit && seg_done && !item_done;
    assign src       = from_seg1 ? seg1_reg : q_entry.s0;

    // Decode the character for the current step
    always_comb
    begin
        o_char   = '0;
        seg_done = 1'b0;
        unique case (phase_reg)
            PH_IDLE:  o_char = '0;
            PH_PFX:   o_char = CH_BSL;
            PH_CHAR:
            begin
                o_char   = char_reg;
                seg_done = 1'b1;
            end
            PH_LINE:
            begin
                o_char   = line_char(line_reg);
                seg_done = (line_reg == 3'd5);
            end
            PH_UBSL:  o_char = CH_BSL;
            PH_U:     o_char = CH_U;
            PH_MINUS: o_char = CH_MINUS;
            PH_DIGIT: o_char = CH_ZERO + {3'd0, dig.digit};
            PH_QMARK:
            begin
                o_char   = CH_QMARK;
                seg_done = 1'b1;
            end
            default:  o_char = '0;
        endcase
    end

    assign o_push = emit;
    assign o_last = item_done;

    // Set up the first step of a segment
    always_comb
    begin
        st_phase = PH_CHAR;
        st_char  = src.val[6:0];
        st_neg   = src.val[15];
        st_mag   = src.val[15] ? (~src.val + 16'd1) : src.val;
        st_pidx  = {2'd0, st_mag >= 16'd10} + {2'd0, st_mag >= 16'd100}
                 + {2'd0, st_mag >= 16'd1000} + {2'd0, st_mag >= 16'd10000};
        if (src.esc)
        begin
            st_phase = PH_UBSL;
        end
        else if (st_char == CH_BSL || st_char == CH_LBRACE || st_char == CH_RBRACE)
        begin
            st_phase = PH_PFX;
        end
        else if (st_char == CH_LF)
        begin
            st_phase = PH_LINE;
        end
    end

    // Advance through the segment, then the next segment or entry
    always_comb
    begin
        phase_next = phase_reg;
        char_next  = char_reg;
        line_next  = line_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        pidx_next  = pidx_reg;
        seg1_next  = seg1_reg;
        two_next   = two_reg;
        cnt_next   = cnt_reg;
        q_pop      = 1'b0;
        load       = 1'b0;
        if (emit)
        begin
            cnt_next = cnt_reg + 4'd1;
            if (item_done)
            begin
                cnt_next = 4'd0;
                if (!q_empty)
                begin
                    load  = 1'b1;
                    q_pop = 1'b1;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            else if (seg_done)
            begin
                load     = 1'b1;
                two_next = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_PFX:   phase_next = PH_CHAR;
                    PH_LINE:  line_next = line_reg + 3'd1;
                    PH_UBSL:  phase_next = PH_U;
                    PH_U:     phase_next = neg_reg ? PH_MINUS : PH_DIGIT;
                    PH_MINUS: phase_next = PH_DIGIT;
                    PH_DIGIT:
                    begin
                        mag_next = dig.rem;
                        if (pidx_reg == 3'd0)
                        begin
                            phase_next = PH_QMARK;
                        end
                        else
                        begin
                            pidx_next = pidx_reg - 3'd1;
                        end
                    end
                    default:  phase_next = phase_reg;
                endcase
            end
        end
        else if (phase_reg == PH_IDLE && !q_empty)
        begin
            load  = 1'b1;
            q_pop = 1'b1;
        end
        if (load)
        begin
            phase_next = st_phase;
            char_next  = st_char;
            line_next  = 3'd0;
            neg_next   = st_neg;
            mag_next   = st_mag;
            pidx_next  = st_pidx;
        end
        if (q_pop)
        begin
            seg1_next = q_entry.s1;
            two_next  = q_entry.two;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            two_reg   <= 1'b0;
            cnt_reg   <= 4'd0;
            line_reg  <= 3'd0;
            pidx_reg  <= 3'd0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            two_reg   <= two_next;
            cnt_reg   <= cnt_next;
            line_reg  <= line_next;
            pidx_reg  <= pidx_next;
            neg_reg   <= neg_next;
        end
    end

    // Segment payload
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        mag_reg  <= mag_next;
        seg1_reg <= seg1_next;
    end

endmodule

// ===== src/utf8_to_rtf_unicode_escape.sv =====
// Top level of the UTF-8 to RTF escaper: front, segment queue, back, result queue.
// A byte's first character passes through the segment queue, back stage and result queue.
// Throughput: one byte per cycle while each gives one character and the queues have room;
// a byte giving k characters (up to 16) holds the back stage, which emits them one a cycle;
// the segment queue lets the front take up to Q_DEPTH more text-giving bytes meanwhile.
// Reset: asynchronous, active low; clears sequence state and both queues, no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8_to_rtf_unicode_escape
    import u2r_pkg::*;
#(
    parameter int Q_DEPTH   = 4,
    parameter int OUT_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       end_of_string,
    output logic       empty,
    input  logic       pop,
    output logic [6:0] out_char,
    output logic       run_last
);

    logic   q_push, q_full, q_pop, q_empty;
    entry_t q_wdata, q_rdata;
    logic   o_push, o_full, o_last;
    logic [6:0] o_char;

    assign full = q_full;

    u2r_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_wdata)
    );

    u2r_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (Q_DEPTH)
    ) u_seg_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    u2r_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_entry (q_rdata),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .o_full  (o_full),
        .o_push  (o_push),
        .o_char  (o_char),
        .o_last  (o_last)
    );

    u2r_fifo #(
        .WIDTH (8),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (o_push),
        .wdata ({o_last, o_char}),
        .full  (o_full),
        .pop   (pop),
        .rdata ({run_last, out_char}),
        .empty (empty)
    );

    // Cross-stage handshake checks
    `ASSERT_NEVER(a_seg_q_overflow, q_push && q_full, "front pushed into a full segment queue")
    `ASSERT_NEVER(a_seg_q_underflow, q_pop && q_empty, "back took an entry from an empty queue")
    `ASSERT_NEVER(a_out_q_overflow, o_push && o_full, "back emitted into a full result queue")
    `ASSERT_ALWAYS(a_pop_refills, (q_pop && !q_push) |=> !q_full, "segment queue full after a pop")

endmodule
